@@ rtl/core/ttds_pkg.sv @@
// shared types and constants for the tone timer divider search block
// no dependencies; used by ttds_div and tone_timer_divider_search_top
`default_nettype none
package ttds_pkg;

   localparam int FREQ_W    = 32;
   localparam int CLK_W     = 32;
   localparam int MULA_W    = 17;              // holds max_count + 2 and any prescaler
   localparam int DIVISOR_W = MULA_W + FREQ_W; // product of prescaler and frequency
   localparam int PRESC_W   = 16;
   localparam int PERIOD_W  = 16;
   localparam int CMP_W     = 15;
   localparam int ACTION_W  = 2;
   localparam int RSP_W     = 56;

   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 32'd72000000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_STOP  = 2'd0,
      ACT_APPLY = 2'd1,
      ACT_RANGE = 2'd2
   } action_type;

   typedef struct packed {
      logic                    start;
      logic [CLK_W-1:0]        dividend;
      logic [DIVISOR_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [CLK_W-1:0]        quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/ttds_div.sv @@
// restoring radix-2 divider, one quotient bit per cycle
// depends on ttds_pkg for widths and the request/response structs
`default_nettype none
module ttds_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ttds_pkg::div_req_type req,
   output ttds_pkg::div_rsp_type      rsp
);

   localparam int CNT_W = $clog2(ttds_pkg::CLK_W);

   logic                             busy_ff;
   logic                             done_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [ttds_pkg::DIVISOR_W-1:0]   rem_ff;
   logic [ttds_pkg::CLK_W-1:0]       quo_ff;

   logic [ttds_pkg::DIVISOR_W:0]     rem_shift;
   logic [ttds_pkg::DIVISOR_W:0]     rem_diff;
   logic                             fits;
   logic [ttds_pkg::DIVISOR_W-1:0]   rem_in;

   // dividend bits shift out of the top of quo_ff while quotient bits enter below
   assign rem_shift = {rem_ff, quo_ff[ttds_pkg::CLK_W-1]};
   assign rem_diff  = rem_shift - {1'b0, req.divisor};
   assign fits      = rem_shift >= {1'b0, req.divisor};
   assign rem_in    = fits ? rem_diff[ttds_pkg::DIVISOR_W-1:0]
                           : rem_shift[ttds_pkg::DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ttds_pkg::CLK_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[ttds_pkg::CLK_W-2:0], fits};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/tone_timer_divider_search_top.sv @@
// top level of the tone timer divider search: csr register, sequencer, result register
// depends on ttds_pkg and ttds_div
`default_nettype none
// A requested tone frequency goes in; prescaler, auto-reload period and a 50% compare
// come out, one result word per request word. A frequency of zero gives a stop word.
// The smallest prescaler whose period fits the counter is found directly as
// floor(clock / ((MAX_COUNT + 2) * freq)) + 1, then checked with a second division of
// clock by prescaler * freq. Both divisions run on one shared bit-serial divider,
// and each is preceded by one 17x32 multiply. The next request word can be taken as
// soon as the result is registered. A result that cannot enter the output register
// holds the sequencer until the output is free.
// One request is worked on at a time; a new request word is taken while the previous
// result still waits on the output.
module tone_timer_divider_search_top #(
   parameter int MAX_COUNT = 65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // timer clock in hertz
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] tone_frequency
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] action, [17:2] prescale_value, [33:18] period_count,
   // [48:34] compare_count, [55:49] zero
   output logic [55:0]      rsp_tdata
);

   localparam logic [ttds_pkg::MULA_W-1:0] SPAN = ttds_pkg::MULA_W'(MAX_COUNT + 2);
   localparam logic [ttds_pkg::CLK_W:0]    MAX_P = (ttds_pkg::CLK_W + 1)'(MAX_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_OUT
   } state_type;

   state_type                          state_ff;
   logic [ttds_pkg::CLK_W-1:0]         clock_hz_ff;
   logic [ttds_pkg::FREQ_W-1:0]        freq_ff;
   logic [ttds_pkg::DIVISOR_W-1:0]     prod_ff;
   logic                               start_ff;
   logic [ttds_pkg::PRESC_W-1:0]       presc_ff;
   logic [ttds_pkg::PERIOD_W-1:0]      period_ff;
   ttds_pkg::action_type               action_ff;

   logic                               rsp_valid_ff;
   ttds_pkg::action_type               rsp_action_ff;
   logic [ttds_pkg::PRESC_W-1:0]       rsp_presc_ff;
   logic [ttds_pkg::PERIOD_W-1:0]      rsp_period_ff;
   logic [ttds_pkg::CMP_W-1:0]         rsp_cmp_ff;

   logic [ttds_pkg::MULA_W-1:0]        mul_a_in;
   logic [ttds_pkg::DIVISOR_W-1:0]     prod_in;
   logic [ttds_pkg::CLK_W:0]           presc_first_in;
   logic [ttds_pkg::CLK_W-1:0]         quot_dec_in;
   logic                               req_fire;
   logic                               rsp_free;

   ttds_pkg::div_req_type              div_req;
   ttds_pkg::div_rsp_type              div_rsp;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign mul_a_in       = (state_ff == ST_MUL1) ? SPAN
                                                 : {{(ttds_pkg::MULA_W - ttds_pkg::PRESC_W){1'b0}},
                                                    presc_ff};
   assign prod_in        = mul_a_in * freq_ff;
   assign presc_first_in = {1'b0, div_rsp.quotient} + 1'b1;
   assign quot_dec_in    = div_rsp.quotient - 1'b1;

   assign div_req.start    = start_ff;
   assign div_req.dividend = clock_hz_ff;
   assign div_req.divisor  = prod_ff;

   ttds_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= ttds_pkg::CLOCK_HZ_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         // the output state reloads the result register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  freq_ff   <= req_tdata;
                  presc_ff  <= '0;
                  period_ff <= '0;
                  if (req_tdata == '0) begin
                     action_ff <= ttds_pkg::ACT_STOP;
                     state_ff  <= ST_OUT;
                  end else begin
                     state_ff <= ST_MUL1;
                  end
               end
            end
            ST_MUL1: begin
               prod_ff  <= prod_in;
               start_ff <= 1'b1;
               state_ff <= ST_DIV1;
            end
            ST_DIV1: begin
               if (div_rsp.done) begin
                  if (presc_first_in > MAX_P) begin
                     action_ff <= ttds_pkg::ACT_RANGE;
                     state_ff  <= ST_OUT;
                  end else begin
                     presc_ff <= presc_first_in[ttds_pkg::PRESC_W-1:0];
                     state_ff <= ST_MUL2;
                  end
               end
            end
            ST_MUL2: begin
               prod_ff  <= prod_in;
               start_ff <= 1'b1;
               state_ff <= ST_DIV2;
            end
            ST_DIV2: begin
               if (div_rsp.done) begin
                  // zero quotient wraps the period, which never fits
                  if (div_rsp.quotient == '0) begin
                     action_ff <= ttds_pkg::ACT_RANGE;
                     presc_ff  <= '0;
                  end else begin
                     action_ff <= ttds_pkg::ACT_APPLY;
                     period_ff <= quot_dec_in[ttds_pkg::PERIOD_W-1:0];
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_action_ff <= action_ff;
                  rsp_presc_ff  <= presc_ff;
                  rsp_period_ff <= period_ff;
                  rsp_cmp_ff    <= period_ff[ttds_pkg::PERIOD_W-1:1];
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cmp_ff, rsp_period_ff, rsp_presc_ff, rsp_action_ff};

endmodule
`default_nettype wire
